// ----- design/b2da_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the binary to decimal ASCII converter.
// Used by b2da_serializer and binary_to_decimal_ascii; no dependencies.
package b2da_pkg;

	localparam int DigitCount = 10;
	localparam int StageCount = DigitCount - 1;
	localparam int ValueWidth = 32;
	localparam int CharWidth  = 6;
	localparam int MultWidth  = 36;

	localparam logic [CharWidth-1:0] AsciiZero = 6'd48;
	localparam logic [3:0] MaxDigit = 4'd9;
	localparam logic [3:0] LastPos  = 4'(DigitCount - 1);

	typedef logic [3:0] digit_t;
	typedef digit_t [DigitCount-1:0] digit_vec_t;

	// One converted item handed from the digit pipeline to the serializer
	typedef struct packed {
		digit_vec_t digits;
		logic       keep_zeros;
	} conv_item_t;

	// Powers of ten, one per pipeline stage, most significant first
	localparam logic [ValueWidth-1:0] PowTen [StageCount] = '{
		32'd1000000000, 32'd100000000, 32'd10000000, 32'd1000000,
		32'd100000, 32'd10000, 32'd1000, 32'd100, 32'd10
	};

endpackage

// ----- design/binary_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// Top level: nine-stage digit extraction pipeline followed by the character serializer.
// Depends on b2da_pkg and b2da_serializer.
// With the serializer free, the first character becomes valid once the item has passed
// through all stage registers and has been loaded into the serializer.
// Each item holds the single output character port for one transfer per character emitted
// (1 to 10), while the nine stages take in the next items meanwhile.
// Reset (arst_n low) clears all stage valid bits and the serializer; no item survives.
module binary_to_decimal_ascii (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [b2da_pkg::ValueWidth-1:0] value,
	input  logic                            keep_zeros,
	output logic                            char_valid,
	input  logic                            char_stall,
	output logic [b2da_pkg::CharWidth-1:0]  digit_char,
	output logic                            last_digit
);
	import b2da_pkg::*;

	// Stage inputs: index 0 is the port side, index g is register stage g
	logic                  st_valid [StageCount];
	logic [ValueWidth-1:0] st_rest  [StageCount];
	digit_vec_t            st_dig   [StageCount];
	logic                  st_keep  [StageCount];

	// Pipeline registers after each stage
	logic                  pipe_valid_s [1:StageCount];
	logic [ValueWidth-1:0] pipe_rest_s  [1:StageCount];
	digit_vec_t            pipe_dig_s   [1:StageCount];
	logic                  pipe_keep_s  [1:StageCount];

	// ready[g]: stage register g+1 can take what stage g offers
	logic       ready [StageCount+1];
	logic       load_ready;
	conv_item_t load_item;

	assign st_valid[0] = item_valid;
	assign st_rest[0]  = value;
	assign st_dig[0]   = '0;
	assign st_keep[0]  = keep_zeros;
	assign item_stall  = ~ready[0];

	assign ready[StageCount] = load_ready;

	for (genvar g = 0; g < StageCount; g++) begin : g_stage
		logic [MultWidth-1:0]  mult [DigitCount];
		logic [3:0]            cnt;
		logic [ValueWidth-1:0] rest_next;
		digit_vec_t            dig_next;

		if (g > 0) begin : g_link
			assign st_valid[g] = pipe_valid_s[g];
			assign st_rest[g]  = pipe_rest_s[g];
			assign st_dig[g]   = pipe_dig_s[g];
			assign st_keep[g]  = pipe_keep_s[g];
		end

		assign ready[g] = ~pipe_valid_s[g+1] | ready[g+1];

		// Count how many multiples of this power fit, then subtract the largest
		always_comb begin
			for (int k = 0; k < DigitCount; k++)
				mult[k] = MultWidth'(k) * MultWidth'(PowTen[g]);
			cnt = 4'd0;
			for (int k = 1; k < DigitCount; k++)
				cnt = cnt + 4'({{(MultWidth-ValueWidth){1'b0}}, st_rest[g]} >= mult[k]);
			rest_next = st_rest[g] - mult[cnt][ValueWidth-1:0];
			dig_next = st_dig[g];
			dig_next[g] = cnt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				pipe_valid_s[g+1] <= 1'b0;
			else if (ready[g])
				pipe_valid_s[g+1] <= st_valid[g];
		end

		always_ff @(posedge clk) begin
			if (ready[g] && st_valid[g]) begin
				pipe_rest_s[g+1] <= rest_next;
				pipe_dig_s[g+1]  <= dig_next;
				pipe_keep_s[g+1] <= st_keep[g];
			end
		end
	end

	// The remainder after the tens stage is the units digit
	always_comb begin
		load_item.digits = pipe_dig_s[StageCount];
		load_item.digits[DigitCount-1] = pipe_rest_s[StageCount][3:0];
		load_item.keep_zeros = pipe_keep_s[StageCount];
	end

	b2da_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (pipe_valid_s[StageCount]),
		.load_item  (load_item),
		.load_ready (load_ready),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

	a_units_small: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_valid_s[StageCount] |-> pipe_rest_s[StageCount] < 32'd10)
		else $error("remainder after tens stage not below ten");

	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pipe_valid_s[StageCount] && !load_ready) |=>
			(pipe_valid_s[StageCount] && $stable(pipe_rest_s[StageCount])))
		else $error("last stage changed while waiting for serializer");

	a_lead_digit: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_valid_s[1] |-> pipe_dig_s[1][0] <= 4'd4)
		else $error("leading digit above four");

endmodule

// ----- design/b2da_serializer.sv -----
`timescale 1ns / 1ps
// Output side: holds one converted item and sends its characters one per transfer.
// Depends on b2da_pkg.
module b2da_serializer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load_valid,
	input  b2da_pkg::conv_item_t         load_item,
	output logic                         load_ready,
	output logic                         char_valid,
	input  logic                         char_stall,
	output logic [b2da_pkg::CharWidth-1:0] digit_char,
	output logic                         last_digit
);
	import b2da_pkg::*;

	logic       busy_q;
	logic [3:0] pos_q;
	digit_vec_t dig_q;
	logic [3:0] start_pos;
	logic       xfer;
	logic       load;

	assign xfer       = busy_q & ~char_stall;
	assign load_ready = ~busy_q | (xfer & last_digit);
	assign load       = load_valid & load_ready;

	// Skip leading zeros unless they are kept; the units digit always goes out
	always_comb begin
		start_pos = LastPos;
		for (int i = StageCount - 1; i >= 0; i--) begin
			if (load_item.digits[i] != 4'd0)
				start_pos = 4'(i);
		end
		if (load_item.keep_zeros)
			start_pos = 4'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= 4'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			pos_q  <= start_pos;
		end else if (xfer) begin
			if (last_digit)
				busy_q <= 1'b0;
			else
				pos_q <= pos_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			dig_q <= load_item.digits;
	end

	assign char_valid = busy_q;
	assign digit_char = AsciiZero + {2'b00, dig_q[pos_q]};
	assign last_digit = (pos_q == LastPos);

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pos_q <= LastPos)
		else $error("character position out of range");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> dig_q[pos_q] <= MaxDigit)
		else $error("decimal digit above nine");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && !last_digit) |=> (busy_q && pos_q == $past(pos_q) + 4'd1))
		else $error("position did not advance after transfer");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && char_stall) |=> (busy_q && $stable(pos_q)))
		else $error("stalled character changed");

endmodule

// ----- dv/decimal_char_checker.sv -----
`timescale 1ns / 1ps
// Watches both channels of binary_to_decimal_ascii, predicts the ASCII digit stream of
// every accepted number and compares each character transfer. Depends on b2da_pkg.
module decimal_char_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	input  logic                            item_stall,
	input  logic [b2da_pkg::ValueWidth-1:0] value,
	input  logic                            keep_zeros,
	input  logic                            char_valid,
	input  logic                            char_stall,
	input  logic [b2da_pkg::CharWidth-1:0]  digit_char,
	input  logic                            last_digit,
	output int                              mismatch_count,
	output int                              chars_pending,
	output int                              items_seen,
	output int                              chars_seen
);
	import b2da_pkg::*;

	localparam int ReportLimit = 10;

	typedef struct {
		logic [CharWidth-1:0] ch;
		logic                 last;
	} digit_char_t;

	digit_char_t expected_chars[$];

	// Split the number by repeated subtraction of powers of ten and queue its characters
	function automatic void queue_decimal_chars(input logic [ValueWidth-1:0] num,
			input logic keep_all);
		logic [ValueWidth-1:0] rest;
		logic [ValueWidth-1:0] step;
		logic [3:0]            digs [DigitCount];
		int                    first;
		digit_char_t           entry;
		rest = num;
		step = 32'd1000000000;
		for (int i = 0; i < DigitCount - 1; i++) begin
			digs[i] = 4'd0;
			while (rest >= step) begin
				rest = rest - step;
				digs[i]++;
			end
			step = step / 10;
		end
		digs[DigitCount-1] = rest[3:0];
		first = 0;
		// drop leading zeros, but always keep the units digit
		if (!keep_all)
			while (first < DigitCount - 1 && digs[first] == 4'd0)
				first++;
		for (int i = first; i < DigitCount; i++) begin
			entry.ch   = AsciiZero + CharWidth'(digs[i]);
			entry.last = (i == DigitCount - 1);
			expected_chars.push_back(entry);
		end
	endfunction

	always @(posedge clk) begin
		digit_char_t want;
		if (arst_n) begin
			if (char_valid && !char_stall) begin
				chars_seen++;
				if (expected_chars.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= ReportLimit)
						$display("ERROR %0t: character %0d last=%b with nothing expected",
							$realtime, digit_char, last_digit);
				end else begin
					want = expected_chars.pop_front();
					if (digit_char !== want.ch || last_digit !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= ReportLimit)
							$display("ERROR %0t: expected char %0d last=%b, got char %0d last=%b",
								$realtime, want.ch, want.last, digit_char, last_digit);
					end
				end
			end
			if (item_valid && !item_stall) begin
				queue_decimal_chars(value, keep_zeros);
				items_seen++;
			end
			chars_pending = expected_chars.size();
		end
	end

endmodule

// ----- dv/tb_binary_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// Top of the binary_to_decimal_ascii testbench: clock, reset, number stimulus and verdict.
// Depends on b2da_pkg, decimal_char_checker and the block itself.
module tb_binary_to_decimal_ascii;
	import b2da_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	logic [ValueWidth-1:0] value = '0;
	logic                  keep_zeros = 1'b0;
	logic                  char_valid;
	logic                  char_stall = 1'b0;
	logic [CharWidth-1:0]  digit_char;
	logic                  last_digit;

	int mismatch_count;
	int chars_pending;
	int items_seen;
	int chars_seen;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	localparam int CornerCount = 12;
	localparam logic [ValueWidth-1:0] CornerValues [CornerCount] = '{
		32'd0, 32'd1, 32'd9, 32'd10, 32'd100, 32'd99999, 32'd1000000000,
		32'd1000000001, 32'd1234567890, 32'd2147483648, 32'd4000000000, 32'hFFFFFFFF
	};

	binary_to_decimal_ascii uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.value      (value),
		.keep_zeros (keep_zeros),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

	decimal_char_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.value          (value),
		.keep_zeros     (keep_zeros),
		.char_valid     (char_valid),
		.char_stall     (char_stall),
		.digit_char     (digit_char),
		.last_digit     (last_digit),
		.mismatch_count (mismatch_count),
		.chars_pending  (chars_pending),
		.items_seen     (items_seen),
		.chars_seen     (chars_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		char_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Hold the number until the transfer; valid stays high when no gap follows
	task automatic send_number(input logic [ValueWidth-1:0] num, input logic keep_all);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		value      <= num;
		keep_zeros <= keep_all;
		do @(posedge clk); while (item_stall);
	endtask

	// Hold off the sender until every queued character has been transferred
	task automatic drain_chars();
		item_valid <= 1'b0;
		@(posedge clk);
		wait (chars_pending == 0);
		@(posedge clk);
	endtask

	// Mix full-range words, shortened words and numbers built from decimal digits
	function automatic logic [ValueWidth-1:0] random_number();
		longint unsigned acc;
		int              ndig;
		acc = 0;
		case ($urandom_range(2))
			0: return $urandom;
			1: return $urandom >> $urandom_range(31);
			default: begin
				ndig = $urandom_range(DigitCount, 1);
				for (int i = 0; i < ndig; i++)
					acc = acc * 10 + (($urandom_range(9) < 3) ? 0 : $urandom_range(9));
				return ValueWidth'(acc % 64'd4294967296);
			end
		endcase
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_number(random_number(), 1'($urandom_range(1)));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 30;
		recv_idle_pct = 63;
		for (int i = 0; i < CornerCount; i++) begin
			send_number(CornerValues[i], 1'b0);
			send_number(CornerValues[i], 1'b1);
		end
		send_random(55);
		drain_chars();

		send_idle_pct = 63;
		recv_idle_pct = 30;
		send_random(25);
		drain_chars();
		send_random(30);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(26);

		drain_chars();
		repeat (20) @(posedge clk);
		$display("Converted %0d numbers in both zero modes into %0d digit characters,",
			items_seen, chars_seen);
		$display("under sender-heavy, receiver-heavy and unthrottled flow control.");
		if (mismatch_count == 0 && chars_pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d characters still expected", chars_pending);
		$display("Verification failed");
		$finish;
	end

endmodule
